// ===== src/lzwd_pkg.sv =====
// lzwd_pkg: shared types and constants of the lzss window decompressor
// used by lzwd_parser and lzss_window_decompressor; depends on nothing
package lzwd_pkg;

    // configuration port
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FILL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 8'd1;
    localparam logic [11:0] START_POSITION_RESET = 12'hFEE;

    // back-reference format
    localparam int LEN_W = 5;
    localparam logic [LEN_W-1:0] LEN_BASE = 5'd3;
    localparam logic [LEN_W-1:0] MAX_RUN = 5'd18;

    // parser phase
    typedef enum logic [1:0] {
        PH_CTRL = 2'd0,
        PH_ITEM = 2'd1,
        PH_HIGH = 2'd2
    } phase_t;

    // what an accepted word asks the sequencer to do
    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_LITERAL = 2'd1,
        CMD_COPY    = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       lit;
        logic [11:0]      offset;
        logic [LEN_W-1:0] length;
    } cmd_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_SWEEP = 2'd0,
        ST_IDLE  = 2'd1,
        ST_READ  = 2'd2,
        ST_EMIT  = 2'd3
    } state_t;

endpackage

// ===== src/lzwd_window_ram.sv =====
// lzwd_window_ram: ring window storage, one write and one read port
// read data registered; depends on nothing
module lzwd_window_ram #(
    parameter int DEPTH = 4096,
    parameter int AW = 12
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lzwd_parser.sv =====
// lzwd_parser: control-byte flag tracking and back-reference decoding
// depends on lzwd_pkg
module lzwd_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    input  logic          stream_last,
    output lzwd_pkg::cmd_t cmd
);
    import lzwd_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] flag_byte_reg, flag_byte_next;
    logic [2:0] flag_index_reg, flag_index_next;
    logic [7:0] held_reg, held_next;
    logic       flag_bit;

    assign flag_bit = flag_byte_reg[flag_index_reg];

    // decode the current word against the parse state
    always_comb begin
        cmd.kind = CMD_NONE;
        cmd.lit = in_byte;
        cmd.offset = {in_byte[7:4], held_reg};
        cmd.length = LEN_BASE + LEN_W'(in_byte[3:0]);
        case (phase_reg)
            PH_ITEM: begin
                if (flag_bit) begin
                    cmd.kind = CMD_LITERAL;
                end
            end
            PH_HIGH: begin
                cmd.kind = CMD_COPY;
            end
            default: begin
                cmd.kind = CMD_NONE;
            end
        endcase
    end

    // parse state update on each accepted word
    always_comb begin
        phase_next = phase_reg;
        flag_byte_next = flag_byte_reg;
        flag_index_next = flag_index_reg;
        held_next = held_reg;
        if (accept) begin
            case (phase_reg)
                PH_ITEM: begin
                    if (flag_bit) begin
                        flag_index_next = flag_index_reg + 3'd1;
                        phase_next = (flag_index_reg == 3'd7) ? PH_CTRL : PH_ITEM;
                    end else begin
                        held_next = in_byte;
                        phase_next = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    flag_index_next = flag_index_reg + 3'd1;
                    phase_next = (flag_index_reg == 3'd7) ? PH_CTRL : PH_ITEM;
                end
                default: begin
                    flag_byte_next = in_byte;
                    flag_index_next = 3'd0;
                    phase_next = PH_ITEM;
                end
            endcase
            // end of stream clears the parser
            if (stream_last) begin
                phase_next = PH_CTRL;
                flag_byte_next = 8'd0;
                flag_index_next = 3'd0;
                held_next = 8'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CTRL;
            flag_byte_reg <= 8'd0;
            flag_index_reg <= 3'd0;
            held_reg <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            flag_byte_reg <= flag_byte_next;
            flag_index_reg <= flag_index_next;
            held_reg <= held_next;
        end
    end

endmodule

// ===== src/lzss_window_decompressor.sv =====
// lzss_window_decompressor: top level, copy sequencer, window sweep, output register
// depends on lzwd_pkg, lzwd_parser, lzwd_window_ram

// Compressed words enter on s_ (one byte each, s_stream_last on the final byte of a
// stream) and decompressed bytes leave on m_, m_run_last marking the last byte caused
// by one input word. A control byte or a reference low byte emits nothing. A literal
// is written to the window and emitted. A back-reference copies 3 to 18 bytes, and
// each copied byte is one window read followed by one write-and-emit, set by the
// window's single registered read port. s_ready is low while a word
// is being worked on, which includes any cycle in which its next byte waits for the
// output register to be taken on m_ready, and in a cycle that carries a register write
// restarting the stream. After reset, after the word that carries s_stream_last, and
// after a register write made before the first word of a stream, the window is refilled
// with window_fill by a sweep of the WINDOW_SIZE entries (4096 by default) in which no
// word is accepted; register writes are always taken and act at the start of the next
// stream.
module lzss_window_decompressor #(
    parameter int WINDOW_SIZE = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_in_byte,
    input  logic                          s_stream_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_out_byte,
    output logic                          m_run_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lzwd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lzwd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lzwd_pkg::*;

    localparam int AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam logic [31:0] IDX_MASK = 32'(WINDOW_SIZE - 1);
    localparam logic [AW-1:0] SWEEP_LAST = AW'(WINDOW_SIZE - 1);

    state_t           state_reg, state_next;
    logic [AW-1:0]    sweep_cnt_reg, sweep_cnt_next;
    logic [AW-1:0]    wp_reg, wp_next;
    logic [AW-1:0]    src_reg, src_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic [7:0]       lit_reg, lit_next;
    logic             use_lit_reg, use_lit_next;
    logic             last_reg, last_next;
    logic             at_start_reg, at_start_next;
    logic [7:0]       fill_reg, fill_next;
    logic [11:0]      start_reg, start_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_byte_reg, m_byte_next;
    logic             m_last_reg, m_last_next;

    cmd_t          cmd;
    logic          accept_in;
    logic          cfg_hit;
    logic          restart;
    logic          out_free;
    logic          emit_go;
    logic [7:0]    emit_byte;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [7:0]    ram_rdata;
    logic [AW-1:0] start_addr;
    logic [AW-1:0] copy_addr;

    lzwd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept_in),
        .in_byte     (s_in_byte),
        .stream_last (s_stream_last),
        .cmd         (cmd)
    );

    lzwd_window_ram #(
        .DEPTH (WINDOW_SIZE),
        .AW    (AW)
    ) u_window (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (src_reg),
        .rdata (ram_rdata)
    );

    // handshake and shared terms
    assign cfg_ready = 1'b1;
    assign accept_in = s_valid && s_ready;
    assign cfg_hit = cfg_valid && (cfg_index == REG_WINDOW_FILL ||
                                   cfg_index == REG_START_POSITION);
    assign restart = cfg_hit && at_start_reg &&
                     (state_reg == ST_SWEEP || state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;
    assign emit_go = (state_reg == ST_EMIT) && out_free;
    assign emit_byte = use_lit_reg ? lit_reg : ram_rdata;

    // window indices folded into range
    assign start_addr = AW'(32'(start_reg) & IDX_MASK);
    assign copy_addr = AW'(32'(cmd.offset) & IDX_MASK);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP: begin
                if (!restart && sweep_cnt_reg == SWEEP_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (restart) begin
                    state_next = ST_SWEEP;
                end else if (accept_in) begin
                    case (cmd.kind)
                        CMD_LITERAL: state_next = ST_EMIT;
                        CMD_COPY:    state_next = ST_READ;
                        default:     state_next = s_stream_last ? ST_SWEEP : ST_IDLE;
                    endcase
                end
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (remain_reg == LEN_W'(1)) begin
                        state_next = last_reg ? ST_SWEEP : ST_IDLE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    // state-decoded controls
    always_comb begin
        s_ready = 1'b0;
        ram_we = 1'b0;
        ram_waddr = wp_reg;
        ram_wdata = emit_byte;
        ram_re = 1'b0;
        case (state_reg)
            ST_SWEEP: begin
                ram_we = 1'b1;
                ram_waddr = sweep_cnt_reg;
                ram_wdata = fill_reg;
            end
            ST_IDLE: begin
                // a restarting register write holds off the input for its cycle
                s_ready = !restart;
            end
            ST_READ: begin
                ram_re = 1'b1;
            end
            ST_EMIT: begin
                ram_we = out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // datapath next values
    always_comb begin
        sweep_cnt_next = (restart || state_reg != ST_SWEEP) ? '0 : sweep_cnt_reg + AW'(1);
        wp_next = wp_reg;
        src_next = src_reg;
        remain_next = remain_reg;
        lit_next = lit_reg;
        use_lit_next = use_lit_reg;
        last_next = last_reg;
        at_start_next = at_start_reg;
        fill_next = fill_reg;
        start_next = start_reg;
        m_valid_next = m_valid_reg;
        m_byte_next = m_byte_reg;
        m_last_next = m_last_reg;

        // register writes
        if (cfg_valid && cfg_index == REG_WINDOW_FILL) begin
            fill_next = cfg_data[7:0];
        end
        if (cfg_valid && cfg_index == REG_START_POSITION) begin
            start_next = cfg_data[11:0];
        end

        // write position reloads while the window is being refilled
        if (state_reg == ST_SWEEP) begin
            wp_next = start_addr;
        end

        // accepted word
        if (accept_in) begin
            last_next = s_stream_last;
            at_start_next = s_stream_last;
            lit_next = cmd.lit;
            case (cmd.kind)
                CMD_LITERAL: begin
                    use_lit_next = 1'b1;
                    remain_next = LEN_W'(1);
                end
                CMD_COPY: begin
                    use_lit_next = 1'b0;
                    remain_next = cmd.length;
                    src_next = copy_addr;
                end
                default: begin
                    use_lit_next = use_lit_reg;
                end
            endcase
        end

        // source address steps after each window read
        if (state_reg == ST_READ) begin
            src_next = AW'(32'(src_reg + AW'(1)) & IDX_MASK);
        end

        // output register
        if (emit_go) begin
            m_valid_next = 1'b1;
            m_byte_next = emit_byte;
            m_last_next = (remain_reg == LEN_W'(1));
            remain_next = remain_reg - LEN_W'(1);
            wp_next = AW'(32'(wp_reg + AW'(1)) & IDX_MASK);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
            sweep_cnt_reg <= '0;
            remain_reg <= '0;
            last_reg <= 1'b0;
            at_start_reg <= 1'b1;
            fill_reg <= 8'd0;
            start_reg <= START_POSITION_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            sweep_cnt_reg <= sweep_cnt_next;
            remain_reg <= remain_next;
            last_reg <= last_next;
            at_start_reg <= at_start_next;
            fill_reg <= fill_next;
            start_reg <= start_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        wp_reg <= wp_next;
        src_reg <= src_next;
        lit_reg <= lit_next;
        use_lit_reg <= use_lit_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_run_last = m_last_reg;

    // a copy in flight always has bytes left to move
    a_remain_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ || state_reg == ST_EMIT) |-> (remain_reg != '0))
        else $error("copy sequencer running with no bytes left");

    // run length never exceeds the longest reference
    a_remain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        remain_reg <= MAX_RUN)
        else $error("run length out of range");

    // the last byte of a run frees the sequencer
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_go && remain_reg == LEN_W'(1)) |=>
            (state_reg == ST_IDLE || state_reg == ST_SWEEP))
        else $error("sequencer did not stop after the last byte of a run");

    // an emitted word marked last ends its run
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_go |=> (m_run_last == (remain_reg == '0)))
        else $error("run_last does not match the end of the run");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking testbench of lzss_window_decompressor, directed table then random streams
// depends on lzwd_pkg and the lzss_window_decompressor rtl

module tb_top;
    import lzwd_pkg::*;

    localparam int WIN_DEPTH     = 4096;
    localparam int PREDICT       = -1;     // row checked against the decoder copy
    localparam int IDLE_PCT      = 38;
    localparam int SETTLE_CYCLES = 48;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_WORDS  = 136;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = 8'hFF;  // no register there

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_word_t;

    typedef struct {
        logic [7:0] b;
        logic       eos;
        int         n;
        logic [7:0] v;
    } vec_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_in_byte;
    logic                  s_stream_last;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_out_byte;
    logic                  m_run_last;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // decoder copy: window, parser and registers
    logic [7:0]  win_mem [WIN_DEPTH];
    logic [11:0] wr_pos;
    logic [7:0]  flag_bits;
    logic [2:0]  flag_pos;
    phase_t      parse_ph;
    logic [7:0]  low_hold;
    bit          stream_fresh;
    logic [7:0]  fill_val;
    logic [11:0] start_val;

    out_word_t step_bytes[$];
    out_word_t pending_bytes[$];

    int          mismatch_count;
    bit          steady;
    int          stall_orders;
    logic [11:0] planned_off;

    // directed words: extremes, overlap, wrap, dropped reference, stream ends
    vec_row_t directed_rows [24] = '{
        '{8'hFE, 1'b0, 0,       8'h00},   // control: ref then seven literals
        '{8'h00, 1'b0, 0,       8'h00},
        '{8'hFF, 1'b0, 18,      8'h00},   // longest ref over the cleared window
        '{8'hFF, 1'b0, 1,       8'hFF},
        '{8'h00, 1'b0, 1,       8'h00},
        '{8'h80, 1'b0, 1,       8'h80},
        '{8'h01, 1'b0, 1,       8'h01},
        '{8'h55, 1'b0, 1,       8'h55},
        '{8'hAA, 1'b0, 1,       8'hAA},
        '{8'h7F, 1'b0, 1,       8'h7F},
        '{8'h00, 1'b0, 0,       8'h00},   // control: all refs
        '{8'h06, 1'b0, 0,       8'h00},
        '{8'h00, 1'b0, PREDICT, 8'h00},   // overlapping copy repeats a byte
        '{8'hFF, 1'b0, 0,       8'h00},
        '{8'hF5, 1'b0, PREDICT, 8'h00},   // source wraps past the window end
        '{8'h12, 1'b1, 0,       8'h00},   // stream ends on a low byte
        '{8'h02, 1'b0, 0,       8'h00},
        '{8'h00, 1'b0, 0,       8'h00},
        '{8'h00, 1'b0, 3,       8'h00},   // shortest ref after refill
        '{8'hC3, 1'b1, 1,       8'hC3},   // stream ends on a literal
        '{8'hFF, 1'b1, 0,       8'h00},   // stream ends on a control byte
        '{8'h00, 1'b0, 0,       8'h00},
        '{8'h10, 1'b0, 0,       8'h00},
        '{8'h0F, 1'b1, 18,      8'h00}    // stream ends on a high byte
    };

    lzss_window_decompressor dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_stream_last (s_stream_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_run_last    (m_run_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // refill window and reset parser at stream start
    function automatic void restart_stream();
        for (int i = 0; i < WIN_DEPTH; i++) win_mem[i] = fill_val;
        wr_pos       = start_val;
        flag_bits    = 8'h00;
        flag_pos     = 3'd0;
        parse_ph     = PH_CTRL;
        low_hold     = 8'h00;
        stream_fresh = 1'b1;
    endfunction

    function automatic void advance_flag();
        if (flag_pos == 3'd7) begin
            flag_pos = 3'd0;
            parse_ph = PH_CTRL;
        end else begin
            flag_pos = flag_pos + 3'd1;
            parse_ph = PH_ITEM;
        end
    endfunction

    function automatic void put_window(input logic [7:0] v);
        win_mem[wr_pos] = v;
        wr_pos = wr_pos + 12'd1;
    endfunction

    // decode one compressed word into step_bytes
    function automatic void decode_word(input logic [7:0] b, input logic eos);
        logic [11:0] src;
        int          cnt;
        logic [7:0]  v;
        step_bytes.delete();
        stream_fresh = 1'b0;
        case (parse_ph)
            PH_ITEM: begin
                if (flag_bits[flag_pos]) begin
                    put_window(b);
                    step_bytes.insert(step_bytes.size(), out_word_t'{data: b, last: 1'b1});
                    advance_flag();
                end else begin
                    low_hold = b;
                    parse_ph = PH_HIGH;
                end
            end
            PH_HIGH: begin
                src = {b[7:4], low_hold};
                cnt = int'(LEN_BASE) + int'(b[3:0]);
                for (int i = 0; i < cnt; i++) begin
                    v   = win_mem[src];
                    src = src + 12'd1;
                    put_window(v);
                    step_bytes.insert(step_bytes.size(),
                                      out_word_t'{data: v, last: (i == cnt - 1)});
                end
                advance_flag();
            end
            default: begin
                flag_bits = b;
                flag_pos  = 3'd0;
                parse_ph  = PH_ITEM;
            end
        endcase
        if (eos) restart_stream();
    endfunction

    // register write: deferred to next stream unless none of this one was taken
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        if (idx == REG_WINDOW_FILL)
            fill_val = val[7:0];
        else if (idx == REG_START_POSITION)
            start_val = val[11:0];
        else
            return;
        if (stream_fresh) restart_stream();
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch: %s", msg);
    endfunction

    // result checker
    always @(posedge aclk) begin : result_check
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_bytes.size() == 0) begin
                note_mismatch($sformatf("unexpected byte %h run_last %b",
                                        m_out_byte, m_run_last));
            end else begin
                want = pending_bytes.pop_front();
                if (want.data !== m_out_byte || want.last !== m_run_last)
                    note_mismatch($sformatf("expected byte %h run_last %b, got byte %h run_last %b",
                                            want.data, want.last, m_out_byte, m_run_last));
            end
        end
    end

    // receiver: random back-pressure, always ready in steady mode, long hold on request
    initial begin : receiver
        int hold_left;
        int orders_seen;
        hold_left   = 0;
        orders_seen = 0;
        m_ready     = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_orders != orders_seen) begin
                orders_seen = stall_orders;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // offer one word, decode it once taken
    task automatic send_word(input logic [7:0] b, input logic eos,
                             input int typed_n, input logic [7:0] typed_v);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_in_byte     <= b;
        s_stream_last <= eos;
        do @(posedge aclk); while (!s_ready);
        decode_word(b, eos);
        if (typed_n == PREDICT) begin
            foreach (step_bytes[k]) pending_bytes.insert(pending_bytes.size(), step_bytes[k]);
        end else begin
            for (int j = 0; j < typed_n; j++)
                pending_bytes.insert(pending_bytes.size(),
                                     out_word_t'{data: typed_v, last: (j == typed_n - 1)});
        end
    endtask

    // register write once the block has settled
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, val);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (pending_bytes.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    // register settings per phase, extremes first
    task automatic configure_phase(input int p);
        logic [CFG_IDX_W-1:0] idx;
        logic [11:0]          sp;
        case (p)
            0: begin
                write_reg(REG_WINDOW_FILL, 12'h0FF);
                write_reg(REG_START_POSITION, 12'hFFF);
            end
            1: begin
                write_reg(REG_WINDOW_FILL, 12'hF00);
                write_reg(REG_START_POSITION, 12'h000);
                write_reg(REG_INDEX_TOP, 12'hABC);
            end
            default: begin
                if ($urandom_range(0, 99) < 50)
                    write_reg(REG_WINDOW_FILL, 12'($urandom));
                if ($urandom_range(0, 99) < 50) begin
                    sp = ($urandom_range(0, 99) < 25) ? START_POSITION_RESET : 12'($urandom);
                    write_reg(REG_START_POSITION, sp);
                end
                if ($urandom_range(0, 99) < 15) begin
                    idx = CFG_IDX_W'($urandom_range(2, 255));
                    write_reg(idx, 12'($urandom));
                end
            end
        endcase
    endtask

    // one stream of mostly well-formed words, continuing the parser state
    task automatic run_stream(inout int sent);
        int         words;
        bit         close;
        logic [7:0] b;
        logic [3:0] len;
        logic       eos;
        words = steady ? 48 : $urandom_range(8, 40);
        close = ($urandom_range(0, 99) < 70);
        for (int k = 0; k < words; k++) begin
            if ($urandom_range(0, 99) < 8) begin
                b = 8'($urandom);
            end else begin
                case (parse_ph)
                    PH_ITEM: begin
                        if (flag_bits[flag_pos]) begin
                            b = 8'($urandom);
                        end else begin
                            if ($urandom_range(0, 99) < 75)
                                planned_off = wr_pos - 12'($urandom_range(1, 24));
                            else
                                planned_off = 12'($urandom);
                            b = planned_off[7:0];
                        end
                    end
                    PH_HIGH: begin
                        len = ($urandom_range(0, 99) < 20) ? 4'hF : 4'($urandom);
                        b   = {planned_off[11:8], len};
                    end
                    default: b = 8'($urandom);
                endcase
            end
            eos = (close && k == words - 1) || ($urandom_range(0, 99) < 3);
            send_word(b, eos, PREDICT, 8'h00);
            sent++;
        end
    endtask

    // main sequence
    initial begin : stimulus
        int sent;
        int p;
        s_valid        = 1'b0;
        s_in_byte      = 8'h00;
        s_stream_last  = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        aresetn        = 1'b0;
        mismatch_count = 0;
        steady         = 1'b0;
        stall_orders   = 0;
        planned_off    = 12'h000;
        fill_val       = 8'h00;
        start_val      = START_POSITION_RESET;
        restart_stream();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_word(directed_rows[i].b, directed_rows[i].eos,
                      directed_rows[i].n, directed_rows[i].v);

        // random streams, sender pausing for a full drain between them
        sent = 0;
        p    = 0;
        while (sent < RANDOM_WORDS) begin
            // the last word was taken, stop offering it
            s_valid <= 1'b0;
            wait_drained();
            configure_phase(p);
            steady = (p == 3);
            if (p == 2) stall_orders++;
            run_stream(sent);
            p++;
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_bytes.size() != 0) begin
            note_mismatch($sformatf("%0d expected bytes never arrived", pending_bytes.size()));
        end
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
